### design/rfrf_pkg.sv
// Shared types, codes and constants of the RFID reader response framer.
// No dependencies; the frame, poll, emit and top design files import this package.
package rfrf_pkg;

   localparam int BUFFER_DEPTH_DEF = 32;
   localparam int FRAME_LEN        = 26;
   localparam int NUM_KEYS         = 8;
   localparam int NUM_REQ          = 5;

   // Input item operations
   typedef enum logic [1:0] {
      OP_BYTE = 2'd0,
      OP_TICK = 2'd1,
      OP_POLL = 2'd2
   } op_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_TIMEOUT    = 2'd0,
      CSR_FIRST_GAP  = 2'd1,
      CSR_SECOND_GAP = 2'd2
   } csr_index_type;

   localparam logic [15:0] TIMEOUT_RESET    = 16'd500;
   localparam logic [7:0]  FIRST_GAP_RESET  = 8'd40;
   localparam logic [7:0]  SECOND_GAP_RESET = 8'd80;

   // Command bytes
   localparam logic [7:0] WAKE_BYTE    = 8'h55;
   localparam logic [7:0] TRIGGER_BYTE = 8'h5A;
   localparam logic [7:0] REQ_BYTES [NUM_REQ] = '{8'h05, 8'h09, 8'h00, 8'h0E, 8'h00};

   // Reply header bytes
   localparam logic [7:0] HDR_CARD_LEN = 8'h18;
   localparam logic [7:0] HDR_CARD_CMD = 8'h09;
   localparam logic [7:0] HDR_CARD_B5  = 8'h01;
   localparam logic [7:0] HDR_CARD_B6  = 8'h04;
   localparam logic [7:0] HDR_NO_CARD  = 8'h06;

   // Frame positions that the decoder looks at: header bytes, then card number
   localparam logic [4:0] KEY_POS [NUM_KEYS] =
      '{5'd2, 5'd3, 5'd5, 5'd6, 5'd14, 5'd15, 5'd16, 5'd17};

   // Result sequence: command bytes at 0..6, status item at 7
   typedef logic [2:0] seq_idx_type;
   localparam seq_idx_type SEQ_WAKE    = 3'd0;
   localparam seq_idx_type SEQ_REQ0    = 3'd1;
   localparam seq_idx_type SEQ_TRIGGER = 3'd6;
   localparam seq_idx_type SEQ_STATUS  = 3'd7;

   typedef struct packed {
      logic        full_frame;   // fill count equals the card frame length
      logic        past_header;  // more than three bytes stored
      logic [7:0]  b2;
      logic [7:0]  b3;
      logic [7:0]  b5;
      logic [7:0]  b6;
      logic [31:0] number;       // bytes 14..17, most significant first
   } frame_view_type;

   typedef struct packed {
      logic        present;
      logic [23:0] short_num;
      logic [31:0] long_num;
   } status_type;

   typedef struct packed {
      logic [7:0] first_gap;
      logic [7:0] second_gap;
   } gaps_type;

   function automatic logic [7:0] cmd_byte(input seq_idx_type idx);
      logic [7:0] b;
      case (idx)
         SEQ_WAKE:    b = WAKE_BYTE;
         3'd1:        b = REQ_BYTES[0];
         3'd2:        b = REQ_BYTES[1];
         3'd3:        b = REQ_BYTES[2];
         3'd4:        b = REQ_BYTES[3];
         3'd5:        b = REQ_BYTES[4];
         SEQ_TRIGGER: b = TRIGGER_BYTE;
         default:     b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

### design/rfrf_req_if.sv
// Input channel of the framer: reader byte, tick or poll.
// No dependencies.
interface rfrf_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] rx_byte;

   modport source (output valid, output op, output rx_byte, input ready);
   modport sink (input valid, input op, input rx_byte, output ready);
endinterface

### design/rfrf_rsp_if.sv
// Result channel of the framer: command bytes and status reports.
// No dependencies.
interface rfrf_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  tx_byte;
   logic [7:0]  gap_ms;
   logic        card_present;
   logic [23:0] card_number_short;
   logic [31:0] card_number_long;
   logic        last;

   modport source (output valid, output kind, output tx_byte, output gap_ms,
                   output card_present, output card_number_short,
                   output card_number_long, output last, input ready);
   modport sink (input valid, input kind, input tx_byte, input gap_ms,
                 input card_present, input card_number_short,
                 input card_number_long, input last, output ready);
endinterface

### design/rfrf_csr_if.sv
// Register write channel of the framer.
// No dependencies.
interface rfrf_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  reg_index;
   logic [15:0] data;

   modport source (output valid, output reg_index, output data, input ready);
   modport sink (input valid, input reg_index, input data, output ready);
endinterface

### design/rfrf_top.sv
// A reader byte or a millisecond tick returns nothing. A poll returns one status item while
// an exchange is open, and otherwise eight items (wake byte, five request bytes, trigger
// byte, status) at one per cycle while the result channel is ready, set by the result
// sequencer that drives one item per transfer. The next input item is taken in the cycle
// the status item transfers, so polls follow each other without a dead cycle. Registers may
// be written at any time the block is idle; the register port is always ready.
//
// Top level of the RFID reader response framer.
// Depends on rfrf_pkg, the channel interfaces, rfrf_frame, rfrf_poll and rfrf_emit.
module rfid_reader_response_framer_top #(
   parameter int BUFFER_DEPTH = rfrf_pkg::BUFFER_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   rfrf_req_if.sink   req_chan,
   rfrf_rsp_if.source rsp_chan,
   rfrf_csr_if.sink   csr_chan
);
   import rfrf_pkg::*;

   logic           in_fire, csr_fire, free;
   logic           frame_clear, send_cmd;
   frame_view_type frame_view;
   status_type     status;
   gaps_type       gaps;

   assign req_chan.ready = free;
   assign csr_chan.ready = 1'b1;
   assign in_fire        = req_chan.valid && req_chan.ready;
   assign csr_fire       = csr_chan.valid && csr_chan.ready;

   rfrf_frame #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) u_frame (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (in_fire && req_chan.op == OP_BYTE),
      .wr_byte (req_chan.rx_byte),
      .clr     (frame_clear),
      .view    (frame_view)
   );

   rfrf_poll u_poll (
      .clock       (clock),
      .reset       (reset),
      .in_fire     (in_fire),
      .in_op       (req_chan.op),
      .csr_fire    (csr_fire),
      .csr_index   (csr_chan.reg_index),
      .csr_data    (csr_chan.data),
      .frame       (frame_view),
      .frame_clear (frame_clear),
      .send_cmd    (send_cmd),
      .status      (status),
      .gaps        (gaps)
   );

   rfrf_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .start    (in_fire && req_chan.op == OP_POLL),
      .send_cmd (send_cmd),
      .status   (status),
      .gaps     (gaps),
      .free     (free),
      .rsp      (rsp_chan)
   );

endmodule

### design/rfrf_frame.sv
// Frame buffer: fill count and the header and card-number bytes of the reply.
// Depends on rfrf_pkg.
module rfrf_frame #(
   parameter int BUFFER_DEPTH = rfrf_pkg::BUFFER_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [7:0]               wr_byte,
   input  logic                     clr,
   output rfrf_pkg::frame_view_type view
);
   import rfrf_pkg::*;

   localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [7:0]        key_ff [NUM_KEYS];
   logic              room;

   // Only the positions the decoder reads are kept; a byte at any other
   // position just advances the fill count. Bytes past the fill count are
   // never looked at, so clearing only resets the count.
   assign room = fill_ff < FILL_W'(BUFFER_DEPTH);

   always_comb begin
      fill_in = fill_ff;
      if (clr) begin
         fill_in = '0;
      end else if (wr_en && room) begin
         fill_in = fill_ff + FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Capture a byte into its slot when it lands at that position
   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
         if (wr_en && room && fill_ff == FILL_W'(KEY_POS[k])) begin
            key_ff[k] <= wr_byte;
         end
      end
   end

   assign view.full_frame  = fill_ff == FILL_W'(FRAME_LEN);
   assign view.past_header = fill_ff > FILL_W'(3);
   assign view.b2          = key_ff[0];
   assign view.b3          = key_ff[1];
   assign view.b5          = key_ff[2];
   assign view.b6          = key_ff[3];
   assign view.number      = {key_ff[4], key_ff[5], key_ff[6], key_ff[7]};

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(BUFFER_DEPTH))
      else $error("fill count beyond buffer depth");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      clr |=> fill_ff == '0)
      else $error("frame not empty after clear");

endmodule

### design/rfrf_poll.sv
// Poll decision logic: registers, elapsed timer, reply decode and card latch.
// Depends on rfrf_pkg.
module rfrf_poll (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_fire,
   input  logic [1:0]               in_op,
   input  logic                     csr_fire,
   input  logic [1:0]               csr_index,
   input  logic [15:0]              csr_data,
   input  rfrf_pkg::frame_view_type frame,
   output logic                     frame_clear,
   output logic                     send_cmd,
   output rfrf_pkg::status_type     status,
   output rfrf_pkg::gaps_type       gaps
);
   import rfrf_pkg::*;

   logic [15:0] timeout_ff;
   logic [7:0]  first_gap_ff;
   logic [7:0]  second_gap_ff;
   logic        awaiting_ff, awaiting_in;
   logic [15:0] elapsed_ff, elapsed_in;
   status_type  status_ff, status_in;

   logic        is_poll, is_tick;
   logic [15:0] elapsed_base;
   logic        card_hit, nocard_hit, timed_out;

   assign is_poll = in_fire && in_op == OP_POLL;
   assign is_tick = in_fire && in_op == OP_TICK;

   // Commands go out only when no exchange is open; sending restarts the timer
   assign send_cmd     = !awaiting_ff;
   assign elapsed_base = send_cmd ? 16'd0 : elapsed_ff;

   // Decode the stored reply; a card frame wins over the no-card answer
   assign card_hit   = frame.full_frame && frame.b2 == HDR_CARD_LEN &&
                       frame.b3 == HDR_CARD_CMD && frame.b5 == HDR_CARD_B5 &&
                       frame.b6 == HDR_CARD_B6;
   assign nocard_hit = !card_hit && frame.past_header && frame.b2 == HDR_NO_CARD;
   assign timed_out  = elapsed_base > timeout_ff;

   assign frame_clear = is_poll && (card_hit || nocard_hit || timed_out);

   always_comb begin
      awaiting_in = awaiting_ff;
      elapsed_in  = elapsed_ff;
      status_in   = status_ff;
      if (is_tick) begin
         if (elapsed_ff != 16'hFFFF) begin
            elapsed_in = elapsed_ff + 16'd1;
         end
      end else if (is_poll) begin
         elapsed_in  = elapsed_base;
         awaiting_in = !(card_hit || nocard_hit || timed_out);
         if (card_hit) begin
            status_in.present   = 1'b1;
            status_in.short_num = frame.number[31:8];
            status_in.long_num  = frame.number;
         end else if (nocard_hit) begin
            status_in.present   = 1'b0;
            status_in.short_num = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff <= 1'b0;
         elapsed_ff  <= '0;
         status_ff   <= '0;
      end else begin
         awaiting_ff <= awaiting_in;
         elapsed_ff  <= elapsed_in;
         status_ff   <= status_in;
      end
   end

   // Register writes; an index beyond the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= TIMEOUT_RESET;
         first_gap_ff  <= FIRST_GAP_RESET;
         second_gap_ff <= SECOND_GAP_RESET;
      end else if (csr_fire) begin
         case (csr_index)
            CSR_TIMEOUT:    timeout_ff    <= csr_data;
            CSR_FIRST_GAP:  first_gap_ff  <= csr_data[7:0];
            CSR_SECOND_GAP: second_gap_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   assign status          = status_ff;
   assign gaps.first_gap  = first_gap_ff;
   assign gaps.second_gap = second_gap_ff;

   a_send_restarts_timer: assert property (@(posedge clock) disable iff (reset)
      is_poll && send_cmd |=> elapsed_ff == 16'd0)
      else $error("timer not restarted by command send");

   a_clear_goes_idle: assert property (@(posedge clock) disable iff (reset)
      frame_clear |=> !awaiting_ff)
      else $error("exchange still open after clear");

endmodule

### design/rfrf_emit.sv
// Result sequencer: steps through command bytes and the closing status item.
// Depends on rfrf_pkg and rfrf_rsp_if.
module rfrf_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 send_cmd,
   input  rfrf_pkg::status_type status,
   input  rfrf_pkg::gaps_type   gaps,
   output logic                 free,
   rfrf_rsp_if.source           rsp
);
   import rfrf_pkg::*;

   logic        busy_ff, busy_in;
   seq_idx_type idx_ff, idx_in;
   logic        is_status, xfer;

   assign is_status = idx_ff == SEQ_STATUS;
   assign xfer      = busy_ff && rsp.ready;
   assign free      = !busy_ff || (rsp.ready && is_status);

   // Load a new sequence, or advance on each transfer and go idle after the status item
   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (start) begin
         busy_in = 1'b1;
         idx_in  = send_cmd ? SEQ_WAKE : SEQ_STATUS;
      end else if (xfer) begin
         if (is_status) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= SEQ_STATUS;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   // Drive the item selected by the sequence index
   always_comb begin
      rsp.valid             = busy_ff;
      rsp.kind              = is_status;
      rsp.last              = is_status;
      rsp.tx_byte           = cmd_byte(idx_ff);
      rsp.card_present      = is_status ? status.present : 1'b0;
      rsp.card_number_short = is_status ? status.short_num : 24'd0;
      rsp.card_number_long  = is_status ? status.long_num : 32'd0;
      case (idx_ff)
         SEQ_REQ0:    rsp.gap_ms = gaps.first_gap;
         SEQ_TRIGGER: rsp.gap_ms = gaps.second_gap;
         default:     rsp.gap_ms = 8'd0;
      endcase
   end

   a_step_order: assert property (@(posedge clock) disable iff (reset)
      xfer && !is_status |=> busy_ff && idx_ff == $past(idx_ff) + 3'd1)
      else $error("command sequence skipped or stalled after transfer");

   a_status_only: assert property (@(posedge clock) disable iff (reset)
      start && !send_cmd |=> busy_ff && idx_ff == SEQ_STATUS)
      else $error("open exchange must report status only");

endmodule

### verif/tb_rfid_reader_response_framer_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the RFID reader response framer: feeds reader bytes, ticks and polls,
// predicts every command byte and status report, and compares each result transfer.
// Depends on rfrf_pkg, the req/rsp/csr channel interfaces and rfid_reader_response_framer_top.
module tb_rfid_reader_response_framer_top;
   import rfrf_pkg::*;

   localparam int         STORE_DEPTH  = BUFFER_DEPTH_DEF;
   localparam int         CYCLE_LIMIT  = 1_000_000;
   localparam int         DRAIN_CYCLES = 8;
   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam logic       KIND_CMD     = 1'b0;
   localparam logic       KIND_STATUS  = 1'b1;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] rx_byte;
   } reader_item_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  tx_byte;
      logic [7:0]  gap_ms;
      logic        card_present;
      logic [23:0] short_num;
      logic [31:0] long_num;
      logic        last;
   } framer_result_type;

   logic clock;
   logic reset;

   rfrf_req_if req_chan ();
   rfrf_rsp_if rsp_chan ();
   rfrf_csr_if csr_chan ();

   rfid_reader_response_framer_top #(.BUFFER_DEPTH(STORE_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Stimulus backlog, results still owed by the block, run bookkeeping
   reader_item_type   reader_backlog [$];
   framer_result_type results_due [$];
   bit                item_on_bus         = 1'b0;
   int                idle_pct            = 10;
   int                error_count         = 0;
   int                cycle_count         = 0;
   int                reader_items_queued = 0;

   // Predicted framer state and register copies
   logic [7:0]  frame_bytes [STORE_DEPTH];
   int          frame_fill;
   bit          reply_open;
   logic [15:0] ms_elapsed;
   logic        card_seen;
   logic [23:0] card_short;
   logic [31:0] card_long;
   logic [15:0] timeout_limit;
   logic [7:0]  gap_before_req;
   logic [7:0]  gap_before_trigger;

   // Clock: 10 ns period
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic framer_result_type cmd_result(input logic [7:0] b, input logic [7:0] gap);
      return '{KIND_CMD, b, gap, 1'b0, 24'd0, 32'd0, 1'b0};
   endfunction

   // Drop the stored reply and go back to idle; the elapsed count is kept
   task automatic clear_frame_bytes();
      foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
      frame_fill = 0;
      reply_open = 1'b0;
   endtask

   // Advance the predicted state by one accepted item, queue the results it causes
   task automatic predict_framer(input logic [1:0] op, input logic [7:0] rx);
      int i;
      case (op)
         OP_BYTE: begin
            if (frame_fill < STORE_DEPTH) begin
               frame_bytes[frame_fill] = rx;
               frame_fill++;
            end
         end
         OP_TICK: begin
            if (ms_elapsed != 16'hFFFF) ms_elapsed++;
         end
         OP_POLL: begin
            // send the command sequence when idle
            if (!reply_open) begin
               results_due.push_back(cmd_result(WAKE_BYTE, 8'd0));
               for (i = 0; i < NUM_REQ; i++)
                  results_due.push_back(cmd_result(REQ_BYTES[i],
                                                   (i == 0) ? gap_before_req : 8'd0));
               results_due.push_back(cmd_result(TRIGGER_BYTE, gap_before_trigger));
               reply_open = 1'b1;
               ms_elapsed = 16'd0;
            end
            // card frame: latch both numbers
            if (reply_open && frame_fill == FRAME_LEN && frame_bytes[2] == HDR_CARD_LEN &&
                frame_bytes[3] == HDR_CARD_CMD && frame_bytes[5] == HDR_CARD_B5 &&
                frame_bytes[6] == HDR_CARD_B6) begin
               card_short = {frame_bytes[14], frame_bytes[15], frame_bytes[16]};
               card_long  = {frame_bytes[14], frame_bytes[15], frame_bytes[16], frame_bytes[17]};
               card_seen  = 1'b1;
               clear_frame_bytes();
            end
            // no-card answer: the long number stays latched
            if (reply_open && frame_fill > 3 && frame_bytes[2] == HDR_NO_CARD) begin
               card_short = 24'd0;
               card_seen  = 1'b0;
               clear_frame_bytes();
            end
            if (ms_elapsed > timeout_limit) clear_frame_bytes();
            results_due.push_back('{KIND_STATUS, 8'h00, 8'h00, card_seen, card_short,
                                    card_long, 1'b1});
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   // Driver: present the next backlog item at the falling edge, hold it until it transfers
   always @(negedge clock) begin
      reader_item_type nxt;
      if (!reset) begin
         if (!item_on_bus && reader_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
            nxt = reader_backlog.pop_front();
            req_chan.valid   <= 1'b1;
            req_chan.op      <= nxt.op;
            req_chan.rx_byte <= nxt.rx_byte;
            item_on_bus = 1'b1;
         end else if (!item_on_bus) begin
            req_chan.valid <= 1'b0;
         end
      end
      rsp_chan.ready <= ($urandom_range(99) >= idle_pct);
   end

   // Monitor: predict on each input transfer, then check each result transfer
   always @(posedge clock) begin
      framer_result_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else if (!reset) begin
         if (req_chan.valid && req_chan.ready && item_on_bus) begin
            predict_framer(req_chan.op, req_chan.rx_byte);
            item_on_bus = 1'b0;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (results_due.size() == 0) begin
               $error("result transfer with nothing expected: kind %0d tx_byte 0x%0h",
                      rsp_chan.kind, rsp_chan.tx_byte);
               error_count++;
            end else begin
               want = results_due.pop_front();
               check_field("kind", 32'(want.kind), 32'(rsp_chan.kind));
               check_field("tx_byte", 32'(want.tx_byte), 32'(rsp_chan.tx_byte));
               check_field("gap_ms", 32'(want.gap_ms), 32'(rsp_chan.gap_ms));
               check_field("card_present", 32'(want.card_present),
                           32'(rsp_chan.card_present));
               check_field("card_number_short", 32'(want.short_num),
                           32'(rsp_chan.card_number_short));
               check_field("card_number_long", want.long_num, rsp_chan.card_number_long);
               check_field("last", 32'(want.last), 32'(rsp_chan.last));
            end
         end
      end
   end

   task automatic add_item(input logic [1:0] op, input logic [7:0] rx);
      reader_backlog.push_back('{op, rx});
      reader_items_queued++;
   endtask

   task automatic add_ticks(input int count);
      repeat (count) add_item(OP_TICK, 8'($urandom));
   endtask

   // Hold until every item has transferred and every result has arrived, then let it settle
   task automatic wait_quiet();
      while (reader_backlog.size() != 0 || item_on_bus || results_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_chan.valid     <= 1'b1;
      csr_chan.reg_index <= idx;
      csr_chan.data      <= value;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         CSR_TIMEOUT:    timeout_limit      = value;
         CSR_FIRST_GAP:  gap_before_req     = value[7:0];
         CSR_SECOND_GAP: gap_before_trigger = value[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic set_config(input logic [15:0] tmo, input logic [7:0] gap1,
                             input logic [7:0] gap2);
      write_csr(CSR_TIMEOUT, tmo);
      write_csr(CSR_FIRST_GAP, {8'd0, gap1});
      write_csr(CSR_SECOND_GAP, {8'd0, gap2});
   endtask

   // Mostly well-formed exchanges with random content, plus noise and broken replies
   task automatic run_random_phase(input int n_items);
      int         stop_at;
      int         pick;
      int         len;
      int         ticks_left;
      int         j;
      bit         broken;
      logic [4:0] spoil_pos;
      logic [7:0] b;
      stop_at = reader_items_queued + n_items;
      while (reader_items_queued < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            // noise: any op, any byte
            repeat ($urandom_range(1, 6)) add_item(2'($urandom_range(3)), 8'($urandom));
         end else begin
            add_item(OP_POLL, 8'($urandom));
            if (pick < 55) begin
               // card frame, a quarter of them with a bad length or a spoiled header byte
               broken     = ($urandom_range(3) == 0);
               len        = broken ? $urandom_range(FRAME_LEN - 1, FRAME_LEN + 1) : FRAME_LEN;
               spoil_pos  = (broken && len == FRAME_LEN) ? KEY_POS[$urandom_range(3)] : 5'd0;
               ticks_left = $urandom_range(6);
               if (ticks_left > timeout_limit) ticks_left = int'(timeout_limit);
               for (j = 0; j < len; j++) begin
                  case (j)
                     2:       b = HDR_CARD_LEN;
                     3:       b = HDR_CARD_CMD;
                     5:       b = HDR_CARD_B5;
                     6:       b = HDR_CARD_B6;
                     default: b = 8'($urandom);
                  endcase
                  if (spoil_pos != 5'd0 && j == spoil_pos) b = b ^ 8'h80;
                  add_item(OP_BYTE, b);
                  if (ticks_left > 0 && $urandom_range(3) == 0) begin
                     add_item(OP_TICK, 8'($urandom));
                     ticks_left--;
                  end
               end
            end else if (pick < 75) begin
               // no-card answer
               len = $urandom_range(4, 8);
               for (j = 0; j < len; j++)
                  add_item(OP_BYTE, (j == 2) ? HDR_NO_CARD : 8'($urandom));
            end else if (pick < 85) begin
               // run the store into its end
               len = $urandom_range(STORE_DEPTH - 2, STORE_DEPTH + 8);
               for (j = 0; j < len; j++)
                  add_item(OP_BYTE, (j == 2) ? 8'h00 : 8'($urandom));
            end else begin
               // no answer: let the exchange time out where the limit is reachable
               add_ticks((timeout_limit < 64) ? int'(timeout_limit) + 1 : 3);
            end
            add_item(OP_POLL, 8'($urandom));
         end
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.op        = OP_BYTE;
      req_chan.rx_byte   = 8'h00;
      rsp_chan.ready     = 1'b0;
      csr_chan.valid     = 1'b0;
      csr_chan.reg_index = CSR_TIMEOUT;
      csr_chan.data      = 16'd0;
      timeout_limit      = TIMEOUT_RESET;
      gap_before_req     = FIRST_GAP_RESET;
      gap_before_trigger = SECOND_GAP_RESET;
      ms_elapsed         = 16'd0;
      card_seen          = 1'b0;
      card_short         = 24'd0;
      card_long          = 32'd0;
      clear_frame_bytes();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: bytes while idle, tick, unused op, send, no-card answer, poll while open
      add_item(OP_BYTE, 8'h00);
      add_item(OP_BYTE, 8'hFF);
      add_item(OP_TICK, 8'hFF);
      add_item(OP_UNUSED, 8'hAA);
      add_item(OP_POLL, 8'h00);
      add_item(OP_BYTE, HDR_NO_CARD);
      add_item(OP_BYTE, 8'h7F);
      add_item(OP_POLL, 8'hFF);
      add_item(OP_UNUSED, 8'h55);
      add_item(OP_POLL, 8'h00);
      add_item(OP_TICK, 8'h00);
      add_item(OP_POLL, 8'h00);
      wait_quiet();

      // Lowest settings: any tick times the exchange out
      set_config(16'd0, 8'd0, 8'd0);
      run_random_phase(55);
      wait_quiet();

      // Highest settings, no idling on either side
      set_config(16'hFFFF, 8'hFF, 8'hFF);
      idle_pct = 0;
      run_random_phase(55);
      wait_quiet();

      // Random mid-range settings
      idle_pct = 10;
      set_config(16'($urandom_range(4, 40)), 8'($urandom), 8'($urandom));
      run_random_phase(55);
      wait_quiet();

      set_config(16'($urandom_range(1, 12)), 8'($urandom), 8'($urandom));
      run_random_phase(45);
      wait_quiet();

      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
